// ===== hw/rtl/dmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmmc_pkg
// Types, codes and small helper functions shared by the distance meter mode
// controller and its channel interfaces.
// ----------------------------------------------------------------------------
package dmmc_pkg;

   // Operating modes, encoded as they appear on the mode_code field.
   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_IDLE   = 3'd1,
      MODE_SINGLE = 3'd2,
      MODE_AVG    = 3'd3,
      MODE_SHOW   = 3'd4
   } mode_type;

   // Display codes other than plain decimal digits.
   localparam logic [3:0] CODE_DASH = 4'd11;
   localparam logic [3:0] CODE_R    = 4'd12;
   localparam logic [3:0] CODE_E    = 4'd14;
   localparam logic [3:0] CODE_P    = 4'd15;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_SPACING = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUX_PERIOD     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_PERIOD   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD = 3'd5;

   localparam logic [6:0] VALUE_MAX = 7'd99;

   typedef struct packed {
      logic       tick;
      logic       press_short;
      logic       press_medium;
      logic       press_long;
      logic       result_ok;
      logic       result_error;
      logic       result_out_of_range;
      logic [6:0] distance_value;
      logic [6:0] light_level;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_code;
      logic       left_enable;
      logic       right_enable;
      logic       led_right;
      logic       led_left;
      logic       measure_request;
      logic [2:0] mode_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] cnt;
      logic        fire;
   } tmr_adv_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   function automatic logic [6:0] clamp99(input logic [6:0] v);
      return (v > VALUE_MAX) ? VALUE_MAX : v;
   endfunction

   // One tick of a 16-bit timer. A period of zero behaves as a period of one.
   function automatic tmr_adv_type tmr_advance(input logic [15:0] cnt,
                                               input logic [15:0] period);
      tmr_adv_type res;
      logic [15:0] nxt;
      nxt = cnt + 16'd1;
      if (nxt >= period || nxt == 16'd0) begin
         res.cnt  = 16'd0;
         res.fire = 1'b1;
      end else begin
         res.cnt  = nxt;
         res.fire = 1'b0;
      end
      return res;
   endfunction

   // Splits a value of at most 99 into tens and units by threshold compares.
   function automatic digits_type split_digits(input logic [6:0] v);
      digits_type res;
      logic [3:0] t;
      logic [6:0] t10;
      t = 4'd0;
      for (int i = 1; i <= 9; i++) begin
         if (v >= 7'(10 * i)) begin
            t = 4'(i);
         end
      end
      t10 = {t, 3'b000} + {2'b00, t, 1'b0};
      res.tens  = t;
      res.units = 4'(v - t10);
      return res;
   endfunction

endpackage

// ===== hw/rtl/dmmc_req_if.sv =====
// ----------------------------------------------------------------------------
// dmmc_req_if
// Input channel: one tick with button, measurement and light events.
// ----------------------------------------------------------------------------
interface dmmc_req_if;
   import dmmc_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dmmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dmmc_rsp_if
// Result channel: registered display, LED, request and mode outputs.
// ----------------------------------------------------------------------------
interface dmmc_rsp_if;
   import dmmc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dmmc_csr_if.sv =====
// ----------------------------------------------------------------------------
// dmmc_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dmmc_csr_if;
   import dmmc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/distance_meter_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// distance_meter_mode_controller_top
// Mode controller of a two-digit distance meter with timers and dark power-off.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on req_chan carries one step: a tick flag, button press
// events, measurement result events, the distance value and the light level.
// Every accepted step produces exactly one transfer on rsp_chan holding the
// digit code, digit enables, LEDs, measurement request and mode.
// The whole step is evaluated in the cycle it is accepted; the result sits in
// the output registers from the next cycle on, and a step can be accepted
// every cycle while the receiver takes results (throughput one step per clock).
// While a result waits on a stalled receiver, req_chan.ready stays high only
// if that result is taken in the same cycle; otherwise input is held off.
// csr_chan writes the six timing and threshold registers (index 0 to 5) and
// is always ready; writes to other indexes are ignored. Registers should only
// be written while no step is in flight.
// Reset (synchronous, active high) returns to mode off with all timers
// stopped except the display multiplex timer, and restores default settings.
// The averaging mean uses one reciprocal multiplier on the stored sum.
// ----------------------------------------------------------------------------
module distance_meter_mode_controller_top #(
   parameter int unsigned AVERAGE_SAMPLES = 9
) (
   input logic         clock,
   input logic         reset,
   dmmc_req_if.sink    req_chan,
   dmmc_rsp_if.source  rsp_chan,
   dmmc_csr_if.sink    csr_chan
);
   import dmmc_pkg::*;

   // Mean by reciprocal multiply; exact for every 10-bit sum and divisor <= 15.
   localparam int unsigned MEAN_SHIFT = 20;
   localparam int unsigned RECIP_W    = MEAN_SHIFT + 1;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((1 << MEAN_SHIFT) + AVERAGE_SAMPLES - 1) / AVERAGE_SAMPLES);
   localparam logic [3:0] AVG_COUNT = 4'(AVERAGE_SAMPLES);
   localparam logic [9:0] SUM_MAX   = 10'd1023;

   // Configuration registers.
   logic [15:0] idle_timeout_ff, show_ticks_ff, sample_spacing_ff, light_period_ff;
   logic [7:0]  mux_period_ff;
   logic [6:0]  dark_threshold_ff;

   // Controller state.
   mode_type    mode_ff, mode_in;
   logic [3:0]  tens_ff, tens_in, units_ff, units_in;
   logic [3:0]  sample_count_ff, sample_count_in;
   logic [9:0]  sample_sum_ff, sample_sum_in;
   logic [6:0]  light_latched_ff, light_latched_in;
   logic        dark_off_ff, dark_off_in;
   logic        display_on_ff, display_on_in;
   logic        prompt_shown_ff, prompt_shown_in;
   logic        mux_phase_ff, mux_phase_in;

   logic [15:0] idle_cnt_ff, idle_cnt_in, show_cnt_ff, show_cnt_in;
   logic [15:0] sample_cnt_ff, sample_cnt_in, light_cnt_ff, light_cnt_in;
   logic [7:0]  mux_cnt_ff, mux_cnt_in;
   logic        idle_run_ff, idle_run_in, show_run_ff, show_run_in;
   logic        sample_run_ff, sample_run_in, light_run_ff, light_run_in;
   logic        idle_exp_ff, idle_exp_in, show_exp_ff, show_exp_in;
   logic        sample_exp_ff, sample_exp_in, mux_exp_ff, mux_exp_in;

   logic [3:0]  digit_ff, digit_in;
   logic        left_ff, left_in, right_ff, right_in;
   logic        led_r_ff, led_r_in, led_l_ff, led_l_in, meas_req_ff, meas_req_in;
   logic        rsp_valid_ff;

   logic        req_fire, csr_fire;
   logic [6:0]  dist_val, light;
   logic [10:0] sum_ext;
   logic [RECIP_W+9:0] mean_prod;
   logic [10:0] mean_full;
   logic [6:0]  mean;
   logic [7:0]  mux_nxt;
   tmr_adv_type idle_adv, show_adv, sample_adv, light_adv;
   digits_type  dist_digits, mean_digits;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   assign dist_val = clamp99(req_chan.data.distance_value);
   assign light    = clamp99(req_chan.data.light_level);

   assign mean_prod   = sample_sum_ff * MEAN_RECIP;
   assign mean_full   = mean_prod[MEAN_SHIFT+10:MEAN_SHIFT];
   assign mean        = (mean_full > 11'(VALUE_MAX)) ? VALUE_MAX : mean_full[6:0];
   assign mean_digits = split_digits(mean);
   assign dist_digits = split_digits(dist_val);
   assign sum_ext     = {1'b0, sample_sum_ff} + {4'b0000, dist_val};

   assign idle_adv   = tmr_advance(idle_cnt_ff, idle_timeout_ff);
   assign show_adv   = tmr_advance(show_cnt_ff, show_ticks_ff);
   assign sample_adv = tmr_advance(sample_cnt_ff, sample_spacing_ff);
   assign light_adv  = tmr_advance(light_cnt_ff, light_period_ff);
   assign mux_nxt    = mux_cnt_ff + 8'd1;

   always_comb begin
      mode_in          = mode_ff;
      tens_in          = tens_ff;
      units_in         = units_ff;
      sample_count_in  = sample_count_ff;
      sample_sum_in    = sample_sum_ff;
      light_latched_in = light_latched_ff;
      dark_off_in      = dark_off_ff;
      display_on_in    = display_on_ff;
      prompt_shown_in  = prompt_shown_ff;
      mux_phase_in     = mux_phase_ff;
      idle_cnt_in      = idle_cnt_ff;
      show_cnt_in      = show_cnt_ff;
      sample_cnt_in    = sample_cnt_ff;
      light_cnt_in     = light_cnt_ff;
      mux_cnt_in       = mux_cnt_ff;
      idle_run_in      = idle_run_ff;
      show_run_in      = show_run_ff;
      sample_run_in    = sample_run_ff;
      light_run_in     = light_run_ff;
      idle_exp_in      = idle_exp_ff;
      show_exp_in      = show_exp_ff;
      sample_exp_in    = sample_exp_ff;
      mux_exp_in       = mux_exp_ff;
      digit_in         = digit_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      led_r_in         = led_r_ff;
      led_l_in         = led_l_ff;
      meas_req_in      = meas_req_ff;

      // Timers advance first; one-shot timers stop when they fire.
      if (req_chan.data.tick) begin
         if (idle_run_ff) begin
            idle_cnt_in = idle_adv.cnt;
            if (idle_adv.fire) begin
               idle_run_in = 1'b0;
               idle_exp_in = 1'b1;
            end
         end
         if (show_run_ff) begin
            show_cnt_in = show_adv.cnt;
            if (show_adv.fire) begin
               show_run_in = 1'b0;
               show_exp_in = 1'b1;
            end
         end
         if (sample_run_ff) begin
            sample_cnt_in = sample_adv.cnt;
            if (sample_adv.fire) begin
               sample_run_in = 1'b0;
               sample_exp_in = 1'b1;
            end
         end
         if (mux_nxt >= mux_period_ff || mux_nxt == 8'd0) begin
            mux_cnt_in = 8'd0;
            mux_exp_in = 1'b1;
         end else begin
            mux_cnt_in = mux_nxt;
         end
         if (light_run_ff) begin
            light_cnt_in = light_adv.cnt;
            if (light_adv.fire) begin
               light_latched_in = light;
            end
         end
      end

      // Display multiplexing alternates tens and units.
      if (mux_exp_in && (display_on_ff || prompt_shown_ff)) begin
         if (mux_phase_ff) begin
            right_in = 1'b0;
            digit_in = display_on_ff ? tens_ff : CODE_P;
            left_in  = 1'b1;
         end else begin
            left_in  = 1'b0;
            digit_in = units_ff;
            right_in = 1'b1;
         end
         mux_phase_in = !mux_phase_ff;
         mux_exp_in   = 1'b0;
      end

      unique case (mode_ff)
         MODE_OFF: begin
            if ((req_chan.data.press_long && !dark_off_ff) ||
                (light_latched_in > dark_threshold_ff && dark_off_ff)) begin
               light_cnt_in  = 16'd0;
               light_run_in  = 1'b1;
               display_on_in = 1'b1;
               mode_in       = MODE_IDLE;
               tens_in       = CODE_DASH;
               units_in      = CODE_DASH;
               idle_cnt_in   = 16'd0;
               idle_run_in   = 1'b1;
               dark_off_in   = 1'b0;
            end
         end
         MODE_IDLE: begin
            priority if (req_chan.data.press_short) begin
               mode_in     = MODE_SINGLE;
               idle_cnt_in = 16'd0;
               idle_run_in = 1'b0;
               meas_req_in = 1'b1;
               led_r_in    = 1'b1;
            end else if (req_chan.data.press_medium) begin
               mode_in         = MODE_AVG;
               idle_cnt_in     = 16'd0;
               idle_run_in     = 1'b0;
               sample_cnt_in   = 16'd0;
               sample_run_in   = 1'b1;
               sample_count_in = 4'd0;
               sample_sum_in   = 10'd0;
               led_l_in        = 1'b1;
               units_in        = CODE_R;
               display_on_in   = 1'b0;
               prompt_shown_in = 1'b1;
            end else if (req_chan.data.press_long || idle_exp_in ||
                         light_latched_in <= dark_threshold_ff) begin
               // Power off; an idle expiry is consumed, darkness is remembered.
               mode_in       = MODE_OFF;
               display_on_in = 1'b0;
               left_in       = 1'b0;
               right_in      = 1'b0;
               idle_cnt_in   = 16'd0;
               idle_run_in   = 1'b0;
               led_l_in      = 1'b0;
               led_r_in      = 1'b0;
               if (!req_chan.data.press_long) begin
                  if (idle_exp_in) begin
                     idle_exp_in = 1'b0;
                  end else begin
                     dark_off_in = 1'b1;
                  end
               end
            end
         end
         MODE_SINGLE: begin
            if (req_chan.data.result_error || req_chan.data.result_out_of_range ||
                req_chan.data.result_ok) begin
               priority if (req_chan.data.result_error) begin
                  units_in = CODE_R;
                  tens_in  = CODE_E;
               end else if (req_chan.data.result_out_of_range) begin
                  units_in = CODE_R;
                  tens_in  = 4'd0;
               end else begin
                  tens_in  = dist_digits.tens;
                  units_in = dist_digits.units;
               end
               mode_in     = MODE_SHOW;
               show_cnt_in = 16'd0;
               show_run_in = 1'b1;
               meas_req_in = 1'b0;
            end
         end
         MODE_SHOW: begin
            if (show_exp_in) begin
               mode_in     = MODE_IDLE;
               idle_cnt_in = 16'd0;
               idle_run_in = 1'b1;
               units_in    = CODE_DASH;
               tens_in     = CODE_DASH;
               led_r_in    = 1'b0;
               show_exp_in = 1'b0;
            end
            meas_req_in = 1'b0;
         end
         MODE_AVG: begin
            priority if (sample_exp_in && sample_count_ff < AVG_COUNT) begin
               sample_count_in = sample_count_ff + 4'd1;
               meas_req_in     = 1'b1;
               sample_sum_in   = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[9:0];
               sample_exp_in   = 1'b0;
               sample_cnt_in   = 16'd0;
               sample_run_in   = 1'b1;
            end else if (sample_count_ff >= AVG_COUNT) begin
               sample_cnt_in   = 16'd0;
               sample_run_in   = 1'b0;
               prompt_shown_in = 1'b0;
               display_on_in   = 1'b1;
               mode_in         = MODE_SHOW;
               tens_in         = mean_digits.tens;
               units_in        = mean_digits.units;
               sample_sum_in   = 10'd0;
               show_cnt_in     = 16'd0;
               show_run_in     = 1'b1;
               led_l_in        = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff   <= 16'd30000;
         show_ticks_ff     <= 16'd5000;
         sample_spacing_ff <= 16'd400;
         mux_period_ff     <= 8'd4;
         light_period_ff   <= 16'd1000;
         dark_threshold_ff <= 7'd10;
      end else if (csr_fire) begin
         unique case (csr_chan.index)
            CSR_IDLE_TIMEOUT:   idle_timeout_ff   <= csr_chan.wdata;
            CSR_SHOW_TICKS:     show_ticks_ff     <= csr_chan.wdata;
            CSR_SAMPLE_SPACING: sample_spacing_ff <= csr_chan.wdata;
            CSR_MUX_PERIOD:     mux_period_ff     <= csr_chan.wdata[7:0];
            CSR_LIGHT_PERIOD:   light_period_ff   <= csr_chan.wdata;
            CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_chan.wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_OFF;
         tens_ff          <= 4'd0;
         units_ff         <= 4'd0;
         sample_count_ff  <= 4'd0;
         sample_sum_ff    <= 10'd0;
         light_latched_ff <= 7'd0;
         dark_off_ff      <= 1'b0;
         display_on_ff    <= 1'b0;
         prompt_shown_ff  <= 1'b0;
         mux_phase_ff     <= 1'b1;
         idle_cnt_ff      <= 16'd0;
         show_cnt_ff      <= 16'd0;
         sample_cnt_ff    <= 16'd0;
         light_cnt_ff     <= 16'd0;
         mux_cnt_ff       <= 8'd0;
         idle_run_ff      <= 1'b0;
         show_run_ff      <= 1'b0;
         sample_run_ff    <= 1'b0;
         light_run_ff     <= 1'b0;
         idle_exp_ff      <= 1'b0;
         show_exp_ff      <= 1'b0;
         sample_exp_ff    <= 1'b0;
         mux_exp_ff       <= 1'b0;
         digit_ff         <= 4'd0;
         left_ff          <= 1'b0;
         right_ff         <= 1'b0;
         led_r_ff         <= 1'b0;
         led_l_ff         <= 1'b0;
         meas_req_ff      <= 1'b0;
      end else if (req_fire) begin
         mode_ff          <= mode_in;
         tens_ff          <= tens_in;
         units_ff         <= units_in;
         sample_count_ff  <= sample_count_in;
         sample_sum_ff    <= sample_sum_in;
         light_latched_ff <= light_latched_in;
         dark_off_ff      <= dark_off_in;
         display_on_ff    <= display_on_in;
         prompt_shown_ff  <= prompt_shown_in;
         mux_phase_ff     <= mux_phase_in;
         idle_cnt_ff      <= idle_cnt_in;
         show_cnt_ff      <= show_cnt_in;
         sample_cnt_ff    <= sample_cnt_in;
         light_cnt_ff     <= light_cnt_in;
         mux_cnt_ff       <= mux_cnt_in;
         idle_run_ff      <= idle_run_in;
         show_run_ff      <= show_run_in;
         sample_run_ff    <= sample_run_in;
         light_run_ff     <= light_run_in;
         idle_exp_ff      <= idle_exp_in;
         show_exp_ff      <= show_exp_in;
         sample_exp_ff    <= sample_exp_in;
         mux_exp_ff       <= mux_exp_in;
         digit_ff         <= digit_in;
         left_ff          <= left_in;
         right_ff         <= right_in;
         led_r_ff         <= led_r_in;
         led_l_ff         <= led_l_in;
         meas_req_ff      <= meas_req_in;
      end
   end

   // The output registers are the controller's own output state; they only
   // change on an accepted step, so they hold while a result is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.data.digit_code      = digit_ff;
   assign rsp_chan.data.left_enable     = left_ff;
   assign rsp_chan.data.right_enable    = right_ff;
   assign rsp_chan.data.led_right       = led_r_ff;
   assign rsp_chan.data.led_left        = led_l_ff;
   assign rsp_chan.data.measure_request = meas_req_ff;
   assign rsp_chan.data.mode_code       = mode_ff;

   a_one_digit_enabled: assert property (@(posedge clock) disable iff (reset)
      !(left_ff && right_ff))
      else $error("both display digits enabled");

   a_single_led: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SINGLE |-> led_r_ff)
      else $error("single mode without its indicator LED");

   a_avg_led: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_AVG |-> led_l_ff && !display_on_ff)
      else $error("averaging mode with wrong LED or display state");

   a_sample_bound: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= AVG_COUNT)
      else $error("sample count beyond the averaging length");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted step produced no result");

endmodule

// ===== verif/distance_meter_mode_controller_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_meter_mode_controller_top_tb
// Drives ticks, button and measurement events into the mode controller and
// checks each result against a fixed expectation or a cycle-free model of
// the modes, timers, display multiplexing and dark power-off kept in this
// bench. Directed steps come first, then random steps under several register
// settings, with random gaps on both channels and one long result back-off.
// ----------------------------------------------------------------------------
module distance_meter_mode_controller_top_tb;
   import dmmc_pkg::*;

   localparam int          N_AVG       = 9;
   localparam int          HOLD_CYCLES = 60;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {TM_IDLE, TM_SHOW, TM_SAMPLE, TM_MUX, TM_LIGHT} timer_id_type;
   typedef enum int {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      bit      fixed;
      rsp_type want;
   } step_note_type;

   typedef struct {
      row_kind_type           kind;
      req_type                item;
      bit                     fixed;
      rsp_type                want;
      logic [CSR_INDEX_W-1:0] index;
      logic [15:0]            wdata;
   } plan_row_type;

   logic clock;
   logic reset;

   dmmc_req_if req_chan ();
   dmmc_rsp_if rsp_chan ();
   dmmc_csr_if csr_chan ();

   distance_meter_mode_controller_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Model state: settings, modes, timers and registered outputs.
   logic [15:0] cfg_idle, cfg_show, cfg_spacing, cfg_light;
   logic [7:0]  cfg_mux;
   logic [6:0]  cfg_dark;
   mode_type    md;
   logic [3:0]  tens_d, units_d, n_samples;
   int unsigned sum_acc;
   logic [6:0]  lux;
   bit          dark_off, disp_on, prompt_on, phase_tens;
   logic [15:0] tcnt [5];
   bit          trun [5];
   bit          expired [5];
   bit          o_left, o_right, o_ledr, o_ledl, o_req;
   logic [3:0]  o_digit;

   rsp_type       display_due [$];
   step_note_type step_notes [$];
   plan_row_type  plan [$];
   int unsigned   steps_sent;
   int unsigned   results_seen;
   int unsigned   mismatch_count;
   bit            hold_pending;
   bit            calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- model ----------------

   function automatic void start_timer(input timer_id_type id);
      tcnt[id] = '0;
      trun[id] = 1'b1;
   endfunction

   function automatic void stop_timer(input timer_id_type id);
      tcnt[id] = '0;
      trun[id] = 1'b0;
   endfunction

   function automatic bit tick_timer(input timer_id_type id, input logic [15:0] period,
                                     input bit periodic);
      logic [15:0] nxt;
      if (!trun[id]) return 1'b0;
      nxt = tcnt[id] + 16'd1;
      // A zero period wraps at once, so it behaves as a period of one.
      if (nxt >= period || nxt == 16'd0) begin
         tcnt[id] = '0;
         if (!periodic) trun[id] = 1'b0;
         return 1'b1;
      end
      tcnt[id] = nxt;
      return 1'b0;
   endfunction

   function automatic void restart_meter();
      cfg_idle    = 16'd30000;
      cfg_show    = 16'd5000;
      cfg_spacing = 16'd400;
      cfg_mux     = 8'd4;
      cfg_light   = 16'd1000;
      cfg_dark    = 7'd10;
      md          = MODE_OFF;
      tens_d      = '0;
      units_d     = '0;
      n_samples   = '0;
      sum_acc     = 0;
      lux         = '0;
      dark_off    = 1'b0;
      disp_on     = 1'b0;
      prompt_on   = 1'b0;
      phase_tens  = 1'b1;
      for (int i = 0; i < 5; i++) begin
         tcnt[i]    = '0;
         trun[i]    = 1'b0;
         expired[i] = 1'b0;
      end
      trun[TM_MUX] = 1'b1;
      o_left  = 1'b0;
      o_right = 1'b0;
      o_ledr  = 1'b0;
      o_ledl  = 1'b0;
      o_req   = 1'b0;
      o_digit = '0;
   endfunction

   function automatic void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                        input logic [15:0] val);
      case (idx)
         CSR_IDLE_TIMEOUT:   cfg_idle    = val;
         CSR_SHOW_TICKS:     cfg_show    = val;
         CSR_SAMPLE_SPACING: cfg_spacing = val;
         CSR_MUX_PERIOD:     cfg_mux     = val[7:0];
         CSR_LIGHT_PERIOD:   cfg_light   = val;
         CSR_DARK_THRESHOLD: cfg_dark    = val[6:0];
         default: ;
      endcase
   endfunction

   function automatic void sleep_meter();
      md      = MODE_OFF;
      disp_on = 1'b0;
      o_left  = 1'b0;
      o_right = 1'b0;
      stop_timer(TM_IDLE);
      o_ledl  = 1'b0;
      o_ledr  = 1'b0;
   endfunction

   function automatic rsp_type step_meter(input req_type r);
      logic [6:0]  dist_val, light;
      int unsigned mean;
      rsp_type     res;
      dist_val = (r.distance_value > 7'd99) ? 7'd99 : r.distance_value;
      light    = (r.light_level > 7'd99) ? 7'd99 : r.light_level;

      if (r.tick) begin
         if (tick_timer(TM_IDLE, cfg_idle, 1'b0)) expired[TM_IDLE] = 1'b1;
         if (tick_timer(TM_SHOW, cfg_show, 1'b0)) expired[TM_SHOW] = 1'b1;
         if (tick_timer(TM_SAMPLE, cfg_spacing, 1'b0)) expired[TM_SAMPLE] = 1'b1;
         if (tick_timer(TM_MUX, {8'd0, cfg_mux}, 1'b1)) expired[TM_MUX] = 1'b1;
         if (tick_timer(TM_LIGHT, cfg_light, 1'b1)) lux = light;
      end

      // The multiplex flag stays pending until something is on the display.
      if (expired[TM_MUX] && (disp_on || prompt_on)) begin
         if (phase_tens) begin
            o_right = 1'b0;
            o_digit = disp_on ? tens_d : CODE_P;
            o_left  = 1'b1;
         end else begin
            o_left  = 1'b0;
            o_digit = units_d;
            o_right = 1'b1;
         end
         phase_tens       = !phase_tens;
         expired[TM_MUX]  = 1'b0;
      end

      case (md)
         MODE_OFF: begin
            if ((r.press_long && !dark_off) || (lux > cfg_dark && dark_off)) begin
               start_timer(TM_LIGHT);
               disp_on  = 1'b1;
               md       = MODE_IDLE;
               tens_d   = CODE_DASH;
               units_d  = CODE_DASH;
               start_timer(TM_IDLE);
               dark_off = 1'b0;
            end
         end
         MODE_IDLE: begin
            if (r.press_short) begin
               md = MODE_SINGLE;
               stop_timer(TM_IDLE);
               o_req  = 1'b1;
               o_ledr = 1'b1;
            end else if (r.press_medium) begin
               md = MODE_AVG;
               stop_timer(TM_IDLE);
               start_timer(TM_SAMPLE);
               n_samples = '0;
               sum_acc   = 0;
               o_ledl    = 1'b1;
               units_d   = CODE_R;
               disp_on   = 1'b0;
               prompt_on = 1'b1;
            end else if (r.press_long) begin
               sleep_meter();
            end else if (expired[TM_IDLE]) begin
               sleep_meter();
               expired[TM_IDLE] = 1'b0;
            end else if (lux <= cfg_dark) begin
               sleep_meter();
               dark_off = 1'b1;
            end
         end
         MODE_SINGLE: begin
            if (r.result_error || r.result_out_of_range || r.result_ok) begin
               if (r.result_error) begin
                  units_d = CODE_R;
                  tens_d  = CODE_E;
               end else if (r.result_out_of_range) begin
                  units_d = CODE_R;
                  tens_d  = 4'd0;
               end else begin
                  tens_d  = 4'(dist_val / 7'd10);
                  units_d = 4'(dist_val % 7'd10);
               end
               md = MODE_SHOW;
               start_timer(TM_SHOW);
               o_req = 1'b0;
            end
         end
         MODE_SHOW: begin
            if (expired[TM_SHOW]) begin
               md = MODE_IDLE;
               start_timer(TM_IDLE);
               units_d = CODE_DASH;
               tens_d  = CODE_DASH;
               o_ledr  = 1'b0;
               expired[TM_SHOW] = 1'b0;
            end
            o_req = 1'b0;
         end
         default: begin
            if (expired[TM_SAMPLE] && n_samples < N_AVG) begin
               n_samples = n_samples + 4'd1;
               o_req     = 1'b1;
               sum_acc   = sum_acc + dist_val;
               if (sum_acc > 1023) sum_acc = 1023;
               expired[TM_SAMPLE] = 1'b0;
               start_timer(TM_SAMPLE);
            end else if (n_samples >= N_AVG) begin
               mean = sum_acc / N_AVG;
               if (mean > 99) mean = 99;
               stop_timer(TM_SAMPLE);
               prompt_on = 1'b0;
               disp_on   = 1'b1;
               md        = MODE_SHOW;
               tens_d    = 4'(mean / 10);
               units_d   = 4'(mean % 10);
               sum_acc   = 0;
               start_timer(TM_SHOW);
               o_ledl    = 1'b0;
            end
         end
      endcase

      res.digit_code      = o_digit;
      res.left_enable     = o_left;
      res.right_enable    = o_right;
      res.led_right       = o_ledr;
      res.led_left        = o_ledl;
      res.measure_request = o_req;
      res.mode_code       = md;
      return res;
   endfunction

   // ---------------- checking ----------------

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_display(input rsp_type got, input rsp_type want);
      if (got.digit_code !== want.digit_code)
         flag_mismatch($sformatf("result %0d digit_code %0d, want %0d", results_seen,
                                 got.digit_code, want.digit_code));
      if (got.left_enable !== want.left_enable)
         flag_mismatch($sformatf("result %0d left_enable %0b, want %0b", results_seen,
                                 got.left_enable, want.left_enable));
      if (got.right_enable !== want.right_enable)
         flag_mismatch($sformatf("result %0d right_enable %0b, want %0b", results_seen,
                                 got.right_enable, want.right_enable));
      if (got.led_right !== want.led_right)
         flag_mismatch($sformatf("result %0d led_right %0b, want %0b", results_seen,
                                 got.led_right, want.led_right));
      if (got.led_left !== want.led_left)
         flag_mismatch($sformatf("result %0d led_left %0b, want %0b", results_seen,
                                 got.led_left, want.led_left));
      if (got.measure_request !== want.measure_request)
         flag_mismatch($sformatf("result %0d measure_request %0b, want %0b", results_seen,
                                 got.measure_request, want.measure_request));
      if (got.mode_code !== want.mode_code)
         flag_mismatch($sformatf("result %0d mode_code %0d, want %0d", results_seen,
                                 got.mode_code, want.mode_code));
   endtask

   // Results are checked before the step accepted at the same edge is
   // predicted; a result always belongs to an earlier transfer.
   always @(posedge clock) begin : scoreboard
      rsp_type       pred;
      step_note_type note;
      if (reset) begin
         restart_meter();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (display_due.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with none expected", results_seen));
            end else begin
               check_display(rsp_chan.data, display_due.pop_front());
            end
         end
         if (csr_chan.valid && csr_chan.ready) set_register(csr_chan.index, csr_chan.wdata);
         if (req_chan.valid && req_chan.ready) begin
            pred = step_meter(req_chan.data);
            note = step_notes.pop_front();
            display_due.push_back(note.fixed ? note.want : pred);
         end
      end
   end

   // ---------------- result side ----------------

   initial begin : result_sink
      int unsigned span;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            span = 0;
            while (span < HOLD_CYCLES) begin
               @(posedge clock);
               span++;
            end
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("distance_meter_mode_controller_top_tb: errors");
      $finish;
   end

   // ---------------- stimulus ----------------

   function automatic req_type ev(input bit tk, input bit ps, input bit pm, input bit pl,
                                  input bit ok, input bit er, input bit oor,
                                  input int unsigned dist_val, input int unsigned light);
      req_type r;
      r.tick                = tk;
      r.press_short         = ps;
      r.press_medium        = pm;
      r.press_long          = pl;
      r.result_ok           = ok;
      r.result_error        = er;
      r.result_out_of_range = oor;
      r.distance_value      = 7'(dist_val);
      r.light_level         = 7'(light);
      return r;
   endfunction

   function automatic rsp_type shown(input logic [3:0] dg, input bit lft, input bit rgt,
                                     input bit lr, input bit ll, input bit rq,
                                     input mode_type m);
      rsp_type r;
      r.digit_code      = dg;
      r.left_enable     = lft;
      r.right_enable    = rgt;
      r.led_right       = lr;
      r.led_left        = ll;
      r.measure_request = rq;
      r.mode_code       = m;
      return r;
   endfunction

   task automatic add_step(input req_type r);
      plan_row_type row;
      row.kind  = ROW_ITEM;
      row.item  = r;
      row.fixed = 1'b0;
      row.want  = '0;
      row.index = '0;
      row.wdata = '0;
      plan.push_back(row);
   endtask

   task automatic add_checked(input req_type r, input rsp_type want);
      plan_row_type row;
      row.kind  = ROW_ITEM;
      row.item  = r;
      row.fixed = 1'b1;
      row.want  = want;
      row.index = '0;
      row.wdata = '0;
      plan.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      plan_row_type row;
      row.kind  = ROW_CSR;
      row.item  = '0;
      row.fixed = 1'b0;
      row.want  = '0;
      row.index = idx;
      row.wdata = val;
      plan.push_back(row);
   endtask

   // Mostly well-formed event traffic with bright light, some plain noise.
   function automatic req_type random_item();
      req_type     r;
      logic [31:0] w;
      int unsigned pick;
      if ($urandom_range(0, 9) == 0) begin
         w = $urandom;
         r = w[$bits(req_type)-1:0];
         return r;
      end
      r = '0;
      r.tick = ($urandom_range(0, 99) < 60);
      pick = $urandom_range(0, 99);
      if (pick < 6) r.press_short = 1'b1;
      else if (pick < 10) r.press_medium = 1'b1;
      else if (pick < 12) r.press_long = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) r.result_ok = 1'b1;
      else if (pick < 13) r.result_error = 1'b1;
      else if (pick < 16) r.result_out_of_range = 1'b1;
      r.distance_value = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                      : 7'($urandom_range(0, 99));
      r.light_level = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(60, 127));
      return r;
   endfunction

   task automatic send_step(input req_type r, input bit fixed, input rsp_type want);
      step_note_type note;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      note.fixed = fixed;
      note.want  = want;
      step_notes.push_back(note);
      req_chan.data  <= r;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      steps_sent++;
   endtask

   task automatic wait_drained();
      while (results_seen < steps_sent) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic apply_setting(input logic [15:0] v_idle, input logic [15:0] v_show,
                                input logic [15:0] v_spacing, input logic [15:0] v_mux,
                                input logic [15:0] v_light, input logic [15:0] v_dark);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_write(CSR_IDLE_TIMEOUT, v_idle);
      csr_write(CSR_SHOW_TICKS, v_show);
      csr_write(CSR_SAMPLE_SPACING, v_spacing);
      csr_write(CSR_MUX_PERIOD, v_mux);
      csr_write(CSR_LIGHT_PERIOD, v_light);
      csr_write(CSR_DARK_THRESHOLD, v_dark);
      csr_write(CSR_SPARE, 16'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int hold_at, input int calm_from);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_pending = 1'b1;
         if (k == calm_from) calm = 1'b1;
         send_step(random_item(), 1'b0, '0);
      end
   endtask

   initial begin : main
      bit csr_open;
      steps_sent     = 0;
      results_seen   = 0;
      mismatch_count = 0;
      hold_pending   = 1'b0;
      calm           = 1'b0;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= '0;
      csr_chan.wdata <= '0;

      // Straight after reset everything is dark and the mode is off.
      add_checked(ev(0, 0, 0, 0, 0, 0, 0, 0, 50), shown(4'd0, 0, 0, 0, 0, 0, MODE_OFF));
      add_checked(ev(1, 0, 0, 0, 0, 0, 0, 0, 0), shown(4'd0, 0, 0, 0, 0, 0, MODE_OFF));
      add_csr(CSR_IDLE_TIMEOUT, 16'd5);
      add_csr(CSR_SHOW_TICKS, 16'd3);
      add_csr(CSR_SAMPLE_SPACING, 16'd1);
      add_csr(CSR_MUX_PERIOD, 16'd1);
      add_csr(CSR_LIGHT_PERIOD, 16'd0);
      add_csr(CSR_DARK_THRESHOLD, 16'd10);
      add_csr(CSR_UNUSED, 16'hFFFF);
      // A long press wakes the meter, but no light has been sampled yet, so
      // the next idle step powers off for darkness; the first light sample
      // (clamped from 127) then wakes it again.
      add_step(ev(0, 0, 0, 1, 0, 0, 0, 0, 50));
      add_step(ev(0, 0, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(1, 0, 0, 0, 0, 0, 0, 0, 127));
      add_step(ev(1, 1, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(1, 0, 0, 0, 0, 1, 0, 0, 50));
      add_checked(ev(1, 0, 0, 0, 0, 0, 0, 0, 50),
                  shown(CODE_E, 1, 0, 1, 0, 0, MODE_SHOW));
      repeat (2) add_step(ev(1, 0, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(0, 1, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(0, 0, 0, 0, 0, 0, 1, 0, 50));
      repeat (3) add_step(ev(1, 0, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(0, 1, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(0, 0, 0, 0, 1, 0, 0, 127, 50));
      repeat (3) add_step(ev(1, 0, 0, 0, 0, 0, 0, 0, 50));
      add_step(ev(0, 0, 1, 0, 0, 0, 0, 0, 50));
      add_step(ev(1, 0, 0, 1, 0, 0, 0, 0, 50));
      add_step(ev(1, 0, 0, 0, 0, 0, 0, 99, 50));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      csr_open = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!csr_open) begin
               req_chan.valid <= 1'b0;
               wait_drained();
            end
            csr_write(plan[i].index, plan[i].wdata);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_chan.valid <= 1'b0;
            csr_open = 1'b0;
            send_step(plan[i].item, plan[i].fixed, plan[i].want);
         end
      end

      apply_setting(16'd12, 16'd4, 16'd1, 16'd2, 16'd3, 16'd20);
      run_random(300, 40, -1);
      apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd99);
      run_random(100, -1, -1);
      apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(200, -1, -1);
      // Every data bit set: the mux period and dark threshold keep their low bits.
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(100, -1, -1);
      apply_setting(16'd40, 16'd6, 16'd3, 16'd3, 16'd5, 16'd50);
      run_random(300, -1, 150);

      req_chan.valid <= 1'b0;
      while (results_seen < steps_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      if (display_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", display_due.size()));
      if (mismatch_count == 0)
         $display("distance_meter_mode_controller_top_tb: clean");
      else
         $display("distance_meter_mode_controller_top_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dmmc_pkg.sv
hw/rtl/dmmc_req_if.sv
hw/rtl/dmmc_rsp_if.sv
hw/rtl/dmmc_csr_if.sv
hw/rtl/distance_meter_mode_controller_top.sv
verif/distance_meter_mode_controller_top_tb.sv
